// ----- rtl/qrr_pkg.sv -----
// Shared widths, codes and transaction types for the quadratic real-roots pipeline.
// Used by every module of the block; depends on nothing.
package qrr_pkg;

   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int CFG_BITS   = 16;

   localparam int PROD_W     = 2 * WORD_BITS;
   localparam int DISC_W     = 2 * WORD_BITS + 2;
   localparam int SQRT_W     = DISC_W / 2;
   localparam int NUM_W      = WORD_BITS + 2;
   localparam int QUO_W      = NUM_W + FRAC_BITS;
   localparam int DEN_W      = WORD_BITS + 1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [0:0] REG_ZERO_THRESHOLD = 1'b0;

   localparam logic [1:0] ROOTS_NONE = 2'd0;
   localparam logic [1:0] ROOTS_TWO  = 2'd2;

   localparam logic [QUO_W-1:0] QUO_ONE       = {{(QUO_W-1){1'b0}}, 1'b1};
   localparam logic [QUO_W-1:0] QUO_NEG_LIMIT = QUO_ONE << (WORD_BITS - 1);
   localparam logic [QUO_W-1:0] QUO_POS_LIMIT = QUO_NEG_LIMIT - QUO_ONE;

   typedef struct packed {
      logic                 valid;
      logic                 none;
      logic [DISC_W-1:0]    disc;
      logic                 a_neg;
      logic [WORD_BITS-1:0] a_mag;
      logic                 b_neg;
      logic [WORD_BITS-1:0] b_mag;
   } disc_type;

   typedef struct packed {
      logic                 valid;
      logic                 none;
      logic [SQRT_W-1:0]    root;
      logic                 a_neg;
      logic [WORD_BITS-1:0] a_mag;
      logic                 b_neg;
      logic [WORD_BITS-1:0] b_mag;
   } sqrt_type;

   typedef struct packed {
      logic                 valid;
      logic [1:0]           count;
      logic [WORD_BITS-1:0] plus;
      logic [WORD_BITS-1:0] minus;
      logic                 sat;
   } result_type;

endpackage

// ----- rtl/quadratic_real_roots.sv -----
// Top level of the quadratic real-roots block: register port, pipeline, output register.
// Depends on qrr_pkg, qrr_disc, qrr_sqrt and qrr_div.
//
//   Channel   Handshake          Payload
//   req_      req_valid/ready    coef_square, coef_linear, coef_free (signed Q16.16)
//   rsp_      rsp_valid/ready    root_count, root_plus, root_minus, saturated
//   config    psel/penable       zero_threshold at byte address 0
//
// One transaction enters per cycle while the result register is not stalled; the square root
// and the divider each resolve one bit per stage.
// Synchronous reset clears all valid bits and sets zero_threshold to 0.
// A stalled result holds the whole pipeline; the first stage still takes a transaction
// when it is empty.
module quadratic_real_roots (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [qrr_pkg::WORD_BITS-1:0]   req_coef_square,
   input  logic signed [qrr_pkg::WORD_BITS-1:0]   req_coef_linear,
   input  logic signed [qrr_pkg::WORD_BITS-1:0]   req_coef_free,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_root_count,
   output logic signed [qrr_pkg::WORD_BITS-1:0]   rsp_root_plus,
   output logic signed [qrr_pkg::WORD_BITS-1:0]   rsp_root_minus,
   output logic                                   rsp_saturated,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [qrr_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [qrr_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [qrr_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready
);

   logic                          advance;
   logic [qrr_pkg::CFG_BITS-1:0]  thr_ff;
   qrr_pkg::disc_type             disc;
   qrr_pkg::sqrt_type             sqrt_r;
   qrr_pkg::result_type           res;
   qrr_pkg::result_type           rsp_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (psel && penable && pwrite && pready
                   && paddr[2] == qrr_pkg::REG_ZERO_THRESHOLD) begin
         thr_ff <= pwdata[qrr_pkg::CFG_BITS-1:0];
      end
   end

   always_comb begin
      unique case (paddr[2])
         qrr_pkg::REG_ZERO_THRESHOLD: prdata = qrr_pkg::CSR_DATA_W'(thr_ff);
         default:                     prdata = '0;
      endcase
   end

   assign advance = ~rsp_ff.valid | rsp_ready;

   qrr_disc u_disc (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .coef_square (req_coef_square),
      .coef_linear (req_coef_linear),
      .coef_free   (req_coef_free),
      .thr         (thr_ff),
      .disc_o      (disc)
   );

   qrr_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .disc_i  (disc),
      .sqrt_o  (sqrt_r)
   );

   qrr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sqrt_i  (sqrt_r),
      .res_o   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else if (advance) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_ff.valid;
   assign rsp_root_count = rsp_ff.count;
   assign rsp_root_plus  = rsp_ff.plus;
   assign rsp_root_minus = rsp_ff.minus;
   assign rsp_saturated  = rsp_ff.sat;

   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_count == qrr_pkg::ROOTS_NONE
      |-> rsp_root_plus == '0 && rsp_root_minus == '0 && !rsp_saturated)
      else $error("result without roots carries nonzero fields");

   a_count_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_root_count == qrr_pkg::ROOTS_NONE
                    || rsp_root_count == qrr_pkg::ROOTS_TWO)
      else $error("root count is neither zero nor two");

   a_sat_needs_roots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_root_count == qrr_pkg::ROOTS_TWO)
      else $error("saturation flagged on a result without roots");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && u_disc.a_valid_ff |-> !req_ready)
      else $error("input taken while the full pipeline is stalled");

endmodule

// ----- rtl/qrr_disc.sv -----
// Input stage, coefficient products and discriminant of the quadratic real-roots pipeline.
// Depends on qrr_pkg.
module qrr_disc (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [qrr_pkg::WORD_BITS-1:0]  coef_square,
   input  logic signed [qrr_pkg::WORD_BITS-1:0]  coef_linear,
   input  logic signed [qrr_pkg::WORD_BITS-1:0]  coef_free,
   input  logic [qrr_pkg::CFG_BITS-1:0]          thr,
   output qrr_pkg::disc_type                     disc_o
);

   localparam int WB = qrr_pkg::WORD_BITS;

   logic                          load_a;
   logic                          a_valid_ff;
   logic                          a_neg_ff, b_neg_ff, c_neg_ff;
   logic [WB-1:0]                 a_mag_ff, b_mag_ff, c_mag_ff;
   logic [WB-1:0]                 a_mag_in, b_mag_in, c_mag_in;

   logic                          p_valid_ff;
   logic [qrr_pkg::PROD_W-1:0]    bb_ff, ac_ff;
   logic                          diff_ff, degen_ff;
   logic                          pa_neg_ff, pb_neg_ff;
   logic [WB-1:0]                 pa_mag_ff, pb_mag_ff;
   logic [WB-1:0]                 thr_ext;

   logic [qrr_pkg::DISC_W-1:0]    bb_x, ac4_x;
   logic                          below;
   qrr_pkg::disc_type             disc_in, disc_ff;

   assign load_a    = advance | ~a_valid_ff;
   assign req_ready = load_a;
   assign a_mag_in  = coef_square[WB-1] ? (~coef_square + 1'b1) : coef_square;
   assign b_mag_in  = coef_linear[WB-1] ? (~coef_linear + 1'b1) : coef_linear;
   assign c_mag_in  = coef_free[WB-1]   ? (~coef_free + 1'b1)   : coef_free;
   assign thr_ext   = WB'(thr);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (load_a) begin
         a_valid_ff <= req_valid;
      end
      if (load_a) begin
         a_neg_ff <= coef_square[WB-1];
         b_neg_ff <= coef_linear[WB-1];
         c_neg_ff <= coef_free[WB-1];
         a_mag_ff <= a_mag_in;
         b_mag_ff <= b_mag_in;
         c_mag_ff <= c_mag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff <= a_valid_ff;
      end
      if (advance) begin
         bb_ff     <= b_mag_ff * b_mag_ff;
         ac_ff     <= a_mag_ff * c_mag_ff;
         diff_ff   <= a_neg_ff ^ c_neg_ff;
         degen_ff  <= a_mag_ff <= thr_ext;
         pa_neg_ff <= a_neg_ff;
         pa_mag_ff <= a_mag_ff;
         pb_neg_ff <= b_neg_ff;
         pb_mag_ff <= b_mag_ff;
      end
   end

   always_comb begin
      bb_x  = {2'b00, bb_ff};
      ac4_x = {ac_ff, 2'b00};
      below = 1'b0;
      if (diff_ff) begin
         disc_in.disc = bb_x + ac4_x;
      end else begin
         below        = bb_x < ac4_x;
         disc_in.disc = bb_x - ac4_x;
      end
      disc_in.valid = p_valid_ff;
      disc_in.none  = degen_ff | below;
      disc_in.a_neg = pa_neg_ff;
      disc_in.a_mag = pa_mag_ff;
      disc_in.b_neg = pb_neg_ff;
      disc_in.b_mag = pb_mag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disc_ff.valid <= 1'b0;
      end else if (advance) begin
         disc_ff <= disc_in;
      end
   end

   assign disc_o = disc_ff;

endmodule

// ----- rtl/qrr_sqrt.sv -----
// Pipelined floor square root of the discriminant, one result bit per stage.
// Depends on qrr_pkg.
module qrr_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  qrr_pkg::disc_type disc_i,
   output qrr_pkg::sqrt_type sqrt_o
);

   localparam int SW    = qrr_pkg::SQRT_W;
   localparam int DW    = qrr_pkg::DISC_W;
   localparam int REM_W = SW + 2;

   typedef struct packed {
      logic                         valid;
      logic                         none;
      logic [DW-1:0]                rad;
      logic [REM_W-1:0]             rem;
      logic [SW-1:0]                root;
      logic                         a_neg;
      logic [qrr_pkg::WORD_BITS-1:0] a_mag;
      logic                         b_neg;
      logic [qrr_pkg::WORD_BITS-1:0] b_mag;
   } step_type;

   step_type st_ff [SW];

   for (genvar k = 0; k < SW; k++) begin : g_step
      step_type         src;
      step_type         nxt;
      logic [REM_W-1:0] rem2;
      logic [REM_W-1:0] trial;

      if (k == 0) begin : g_first
         always_comb begin
            src       = '0;
            src.valid = disc_i.valid;
            src.none  = disc_i.none;
            src.rad   = disc_i.disc;
            src.a_neg = disc_i.a_neg;
            src.a_mag = disc_i.a_mag;
            src.b_neg = disc_i.b_neg;
            src.b_mag = disc_i.b_mag;
         end
      end else begin : g_next
         assign src = st_ff[k-1];
      end

      always_comb begin
         nxt     = src;
         rem2    = {src.rem[REM_W-3:0], src.rad[DW-1 -: 2]};
         trial   = {src.root, 2'b01};
         nxt.rad = src.rad << 2;
         if (rem2 >= trial) begin
            nxt.rem  = rem2 - trial;
            nxt.root = {src.root[SW-2:0], 1'b1};
         end else begin
            nxt.rem  = rem2;
            nxt.root = {src.root[SW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[k].valid <= 1'b0;
         end else if (advance) begin
            st_ff[k] <= nxt;
         end
      end
   end

   assign sqrt_o.valid = st_ff[SW-1].valid;
   assign sqrt_o.none  = st_ff[SW-1].none;
   assign sqrt_o.root  = st_ff[SW-1].root;
   assign sqrt_o.a_neg = st_ff[SW-1].a_neg;
   assign sqrt_o.a_mag = st_ff[SW-1].a_mag;
   assign sqrt_o.b_neg = st_ff[SW-1].b_neg;
   assign sqrt_o.b_mag = st_ff[SW-1].b_mag;

endmodule

// ----- rtl/qrr_div.sv -----
// Numerator forming, two-lane pipelined restoring divider and root clamping.
// Depends on qrr_pkg.
module qrr_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  qrr_pkg::sqrt_type   sqrt_i,
   output qrr_pkg::result_type res_o
);

   localparam int WB  = qrr_pkg::WORD_BITS;
   localparam int NW  = qrr_pkg::NUM_W + 1;
   localparam int QW  = qrr_pkg::QUO_W;
   localparam int DNW = qrr_pkg::DEN_W;

   typedef struct packed {
      logic           neg;
      logic [DNW-1:0] rem;
      logic [QW-1:0]  nq;
   } lane_type;

   typedef struct packed {
      logic           valid;
      logic           none;
      logic [DNW-1:0] den;
      lane_type       plus;
      lane_type       minus;
   } stage_type;

   function automatic lane_type div_step(lane_type l, logic [DNW-1:0] den);
      logic [DNW:0] rem2;
      logic [DNW:0] diff;
      logic         ge;
      lane_type     r;
      rem2   = {l.rem, l.nq[QW-1]};
      diff   = rem2 - {1'b0, den};
      ge     = rem2 >= {1'b0, den};
      r      = l;
      r.rem  = ge ? diff[DNW-1:0] : rem2[DNW-1:0];
      r.nq   = {l.nq[QW-2:0], ge};
      return r;
   endfunction

   function automatic logic [WB:0] clamp(lane_type l);
      logic          sat;
      logic [QW-1:0] m;
      logic [QW-1:0] neg_m;
      if (l.neg) begin
         sat   = l.nq > qrr_pkg::QUO_NEG_LIMIT;
         m     = sat ? qrr_pkg::QUO_NEG_LIMIT : l.nq;
         neg_m = ~m + qrr_pkg::QUO_ONE;
         return {sat, neg_m[WB-1:0]};
      end else begin
         sat = l.nq > qrr_pkg::QUO_POS_LIMIT;
         m   = sat ? qrr_pkg::QUO_POS_LIMIT : l.nq;
         return {sat, m[WB-1:0]};
      end
   endfunction

   logic signed [NW-1:0] s_x, b_x, b_v, n_plus, n_minus, m_plus, m_minus;
   stage_type            front_in, front_ff;
   stage_type            dv_ff [QW];
   logic [WB:0]          c_plus, c_minus;

   always_comb begin
      s_x     = signed'(NW'(sqrt_i.root));
      b_x     = signed'(NW'(sqrt_i.b_mag));
      b_v     = sqrt_i.b_neg ? -b_x : b_x;
      n_plus  = s_x - b_v;
      n_minus = -s_x - b_v;
      m_plus  = n_plus[NW-1] ? -n_plus : n_plus;
      m_minus = n_minus[NW-1] ? -n_minus : n_minus;

      front_in.valid     = sqrt_i.valid;
      front_in.none      = sqrt_i.none;
      front_in.den       = {sqrt_i.a_mag, 1'b0};
      front_in.plus.neg  = n_plus[NW-1] ^ sqrt_i.a_neg;
      front_in.plus.rem  = '0;
      front_in.plus.nq   = QW'(m_plus[NW-2:0]) << qrr_pkg::FRAC_BITS;
      front_in.minus.neg = n_minus[NW-1] ^ sqrt_i.a_neg;
      front_in.minus.rem = '0;
      front_in.minus.nq  = QW'(m_minus[NW-2:0]) << qrr_pkg::FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else if (advance) begin
         front_ff <= front_in;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      stage_type src;
      stage_type nxt;

      if (k == 0) begin : g_first
         assign src = front_ff;
      end else begin : g_next
         assign src = dv_ff[k-1];
      end

      always_comb begin
         nxt       = src;
         nxt.plus  = div_step(src.plus, src.den);
         nxt.minus = div_step(src.minus, src.den);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k].valid <= 1'b0;
         end else if (advance) begin
            dv_ff[k] <= nxt;
         end
      end
   end

   always_comb begin
      c_plus      = clamp(dv_ff[QW-1].plus);
      c_minus     = clamp(dv_ff[QW-1].minus);
      res_o.valid = dv_ff[QW-1].valid;
      if (dv_ff[QW-1].none) begin
         res_o.count = qrr_pkg::ROOTS_NONE;
         res_o.plus  = '0;
         res_o.minus = '0;
         res_o.sat   = 1'b0;
      end else begin
         res_o.count = qrr_pkg::ROOTS_TWO;
         res_o.plus  = c_plus[WB-1:0];
         res_o.minus = c_minus[WB-1:0];
         res_o.sat   = c_plus[WB] | c_minus[WB];
      end
   end

endmodule

// ----- dv/tb_quadratic_real_roots.sv -----
// Testbench for quadratic_real_roots: directed and random coefficient sets, a scoreboard
// class that predicts the roots, random stalls on both channels and register writes.
// Depends on qrr_pkg and the quadratic_real_roots RTL.
`timescale 1ns / 100ps

module tb_quadratic_real_roots;

   typedef struct {
      logic [1:0]  count;
      logic [31:0] plus;
      logic [31:0] minus;
      logic        sat;
   } roots_type;

   class roots_scoreboard;
      roots_type   pending[$];
      logic [15:0] threshold;
      int          mismatches;
      int          failures;

      function new();
         threshold  = 0;
         mismatches = 0;
         failures   = 0;
      endfunction

      function void split(logic [31:0] v, output bit neg, output logic [32:0] mag);
         neg = v[31];
         mag = neg ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
      endfunction

      function logic [31:0] one_root(longint numer, bit a_neg, logic [32:0] a_mag,
                                     inout bit sat);
         bit           n_neg;
         logic [127:0] n_mag;
         logic [127:0] quo;
         logic [127:0] lim;
         logic [31:0]  m;
         n_neg = numer < 0;
         n_mag = n_neg ? 128'(-numer) : 128'(numer);
         lim   = 128'h8000_0000;
         quo   = (n_mag << qrr_pkg::FRAC_BITS) / (128'(a_mag) << 1);
         if (n_neg != a_neg) begin
            if (quo > lim) begin
               sat = 1;
               quo = lim;
            end
            m = 32'(quo);
            return -m;
         end
         if (quo > lim - 1) begin
            sat = 1;
            quo = lim - 1;
         end
         return 32'(quo);
      endfunction

      function void note(logic [31:0] a, logic [31:0] b, logic [31:0] c);
         roots_type    r;
         bit           an, bn, cn, sat;
         logic [32:0]  am, bm, cm;
         logic [127:0] bb, ac4, d, s, t;
         longint       bv;
         r = '{qrr_pkg::ROOTS_NONE, 32'd0, 32'd0, 1'b0};
         split(a, an, am);
         split(b, bn, bm);
         split(c, cn, cm);
         if (am > {17'd0, threshold}) begin
            bb  = 128'(bm) * 128'(bm);
            ac4 = (128'(am) * 128'(cm)) << 2;
            if (an != cn || bb >= ac4) begin
               d = (an != cn) ? bb + ac4 : bb - ac4;
               s = 0;
               for (int i = 36; i >= 0; i--) begin
                  t = s | (128'd1 << i);
                  if (t * t <= d) s = t;
               end
               bv      = bn ? -longint'(bm) : longint'(bm);
               sat     = 0;
               r.count = qrr_pkg::ROOTS_TWO;
               r.plus  = one_root(longint'(s) - bv, an, am, sat);
               r.minus = one_root(-longint'(s) - bv, an, am, sat);
               r.sat   = sat;
            end
         end
         pending.push_back(r);
      endfunction

      function void check(logic [1:0] count, logic [31:0] plus, logic [31:0] minus,
                          logic sat);
         roots_type e;
         if (pending.size() == 0) begin
            failures++;
            $display("Unexpected result transaction: count %0d", count);
            return;
         end
         e = pending.pop_front();
         if (count !== e.count || plus !== e.plus || minus !== e.minus || sat !== e.sat)
         begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected %0d %h %h %b, got %0d %h %h %b",
                        e.count, e.plus, e.minus, e.sat, count, plus, minus, sat);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [31:0] req_coef_square = 0;
   logic [31:0] req_coef_linear = 0;
   logic [31:0] req_coef_free = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_root_count;
   logic [31:0] rsp_root_plus;
   logic [31:0] rsp_root_minus;
   logic        rsp_saturated;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [qrr_pkg::CSR_ADDR_W-1:0] paddr = 0;
   logic [qrr_pkg::CSR_DATA_W-1:0] pwdata = 0;
   logic [qrr_pkg::CSR_DATA_W-1:0] prdata;
   logic        pready;

   roots_scoreboard board = new();
   int          idle_cycles = 0;
   int          hold_left = 0;
   bit          stall_free = 0;

   quadratic_real_roots dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.note(req_coef_square, req_coef_linear, req_coef_free);
      if (!reset && rsp_valid && rsp_ready)
         board.check(rsp_root_count, rsp_root_plus, rsp_root_minus, rsp_saturated);
   end

   // Receiver side: runs of ready and stalls, mostly short, occasionally long.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (stall_free) begin
         rsp_ready <= 1;
         stall_free <= ($urandom_range(0, 199) != 0);
      end else begin
         rsp_ready <= ~rsp_ready;
         hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(0, 3);
         stall_free <= ($urandom_range(0, 29) == 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 20000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      int gap;
      req_valid       <= 1;
      req_coef_square <= a;
      req_coef_linear <= b;
      req_coef_free   <= c;
      do @(posedge clock); while (!req_ready);
      gap = ($urandom_range(0, 3) == 0) ?
            (($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3)) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_threshold(logic [15:0] value);
      psel    <= 1;
      penable <= 0;
      pwrite  <= 1;
      paddr   <= {qrr_pkg::REG_ZERO_THRESHOLD, 2'b00};
      pwdata  <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      board.threshold = value;
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
      @(posedge clock);
   endtask

   task automatic random_items(int n);
      logic [31:0] a, b, c;
      int          kind;
      for (int i = 0; i < n; i++) begin
         a    = $urandom;
         b    = $urandom;
         c    = $urandom;
         kind = $urandom_range(0, 5);
         if (kind == 1 || kind == 2) begin
            a = $signed(a) >>> $urandom_range(4, 24);
            b = $signed(b) >>> $urandom_range(4, 24);
            c = $signed(c) >>> $urandom_range(4, 24);
         end
         if (kind == 2 || kind == 3)
            c[31] = ~a[31];
         if (kind == 4)
            a = $urandom_range(0, 1) ? {16'd0, board.threshold} + $urandom_range(0, 2)
                                     : -({16'd0, board.threshold} + $urandom_range(0, 2));
         send(a, b, c);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_threshold(16'd0);
      send(32'h0, 32'h1234_5678, 32'h0001_0000);
      send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
      send(32'hFFFF_0000, 32'h0002_0000, 32'hFFFF_0000);
      send(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
      send(32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0000);
      send(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001);
      send(32'h0000_0001, 32'h0000_0000, 32'h8000_0000);
      send(32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000);
      send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      random_items(200);
      drain();
      write_threshold(16'hFFFF);
      send(32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_0000);
      send(32'hFFFF_0001, 32'h0001_0000, 32'h0001_0000);
      send(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
      send(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000);
      random_items(180);
      drain();
      write_threshold(16'($urandom_range(2, 65534)));
      random_items(160);
      drain();
      write_threshold(16'd1);
      send(32'h0000_0001, 32'h0000_0010, 32'h0000_0000);
      send(32'h0000_0002, 32'h7FFF_FFFF, 32'h8000_0000);
      random_items(160);
      drain();
      if (board.failures == 0 && board.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/qrr_pkg.sv
rtl/qrr_disc.sv
rtl/qrr_sqrt.sv
rtl/qrr_div.sv
rtl/quadratic_real_roots.sv
dv/tb_quadratic_real_roots.sv
